// ===== hdl/dat_pkg.sv =====
// Shared types and constants for the delayed action timer bank.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none
package dat_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ELAPSED_W  = 25;
  localparam int DELAY_W    = 24;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [1:0] OP_TRIGGER = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         slot;
    logic [7:0]         channel;
    logic               action;
    logic [DELAY_W-1:0] delay_ms;
  } dat_in_t;

  typedef struct packed {
    logic [3:0] fired_slot;
    logic [7:0] fired_channel;
    logic       fired_action;
    logic       last;
  } dat_out_t;

  typedef enum logic [1:0] {
    CMD_ARM,
    CMD_DISARM,
    CMD_TICK
  } dat_kind_t;

  typedef struct packed {
    dat_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [7:0]         channel;
    logic               action;
    logic [DELAY_W-1:0] delay;
  } dat_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } dat_bk_state_t;

endpackage
`default_nettype wire

// ===== hdl/delayed_action_timer_bank_unit.sv =====
// Top level of the delayed action timer bank: front part, command queue, back part.
// Depends on dat_pkg, dat_front, dat_cmd_queue and dat_back.
//
//   port group | dir | payload    | handshake
//   in_*       | in  | dat_in_t   | in_valid / in_stall
//   out_*      | out | dat_out_t  | out_valid / out_stall
//
// In the back part trigger and cancel are done as they are popped; a tick is popped, then
// scans every slot in turn and then flushes, and it can also wait on out_stall.
// The front register and a four-entry queue keep taking items while a tick scans.
// Synchronous active-low reset disarms every slot and empties the queue.
// out_stall holds the scan when a second expired slot finds the output busy, and holds
// the flush cycle until the final result of the tick can move to the output.
`default_nettype none
module delayed_action_timer_bank_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  dat_pkg::dat_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output dat_pkg::dat_out_t out_data
);
  import dat_pkg::*;

  logic     f_valid;
  logic     f_ready;
  dat_cmd_t f_cmd;
  logic     q_valid;
  logic     q_pop;
  dat_cmd_t q_cmd;

  dat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_cmd)
  );

  dat_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_cmd)
  );

  dat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd_data  (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/dat_front.sv =====
// Front part: takes input transfers, drops ignored items, turns the rest into commands.
// Depends on dat_pkg.
`default_nettype none
module dat_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  dat_pkg::dat_in_t in_data,
  output logic             cmd_valid,
  input  wire              cmd_ready,
  output dat_pkg::dat_cmd_t cmd_data
);
  import dat_pkg::*;

  logic     hold_v_r;
  logic     hold_v_nxt;
  dat_cmd_t hold_r;
  dat_cmd_t hold_nxt;
  logic     in_accept;
  logic     keep;
  logic     slot_ok;

  assign in_stall  = hold_v_r && !cmd_ready;
  assign in_accept = in_valid && !in_stall;
  assign cmd_valid = hold_v_r;
  assign cmd_data  = hold_r;

  always_comb begin
    slot_ok          = (32'(in_data.slot) < SLOTS);
    hold_nxt         = hold_r;
    hold_nxt.slot    = SLOT_W'(in_data.slot);
    hold_nxt.channel = in_data.channel;
    hold_nxt.action  = in_data.action;
    hold_nxt.delay   = in_data.delay_ms;
    keep             = 1'b0;
    case (in_data.op)
      OP_TRIGGER: begin
        hold_nxt.kind = CMD_ARM;
        keep          = slot_ok;
      end
      OP_CANCEL: begin
        hold_nxt.kind = CMD_DISARM;
        keep          = slot_ok;
      end
      OP_TICK: begin
        hold_nxt.kind = CMD_TICK;
        keep          = 1'b1;
      end
      default: begin
        hold_nxt.kind = CMD_TICK;
        keep          = 1'b0;
      end
    endcase
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_accept) begin
      hold_v_nxt = keep;
    end else if (cmd_ready) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dat_cmd_queue.sv =====
// Short command queue between the front and back parts.
// Depends on dat_pkg.
`default_nettype none
module dat_cmd_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push_valid,
  output logic              push_ready,
  input  dat_pkg::dat_cmd_t push_data,
  output logic              pop_valid,
  input  wire               pop,
  output dat_pkg::dat_cmd_t pop_data
);
  import dat_pkg::*;

  dat_cmd_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dat_back.sv =====
// Back part: holds the slot table, runs arm and cancel, scans slots on each tick.
// Depends on dat_pkg.
`default_nettype none
module dat_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cmd_valid,
  output logic              cmd_pop,
  input  dat_pkg::dat_cmd_t cmd_data,
  output logic              out_valid,
  input  wire               out_stall,
  output dat_pkg::dat_out_t out_data
);
  import dat_pkg::*;

  logic [SLOTS-1:0]     armed_r;
  logic [7:0]           chan_r  [SLOTS];
  logic                 act_r   [SLOTS];
  logic [DELAY_W-1:0]   delay_r [SLOTS];
  logic [ELAPSED_W-1:0] elap_r  [SLOTS];

  dat_bk_state_t        state_r;
  dat_bk_state_t        state_nxt;
  logic [SLOT_W-1:0]    idx_r;
  logic                 pend_v_r;
  dat_out_t             pend_r;
  logic                 out_valid_r;
  dat_out_t             out_r;

  logic [ELAPSED_W-1:0] elap_cur;
  logic [ELAPSED_W-1:0] elap_inc;
  logic                 fire;
  logic                 out_free;
  logic                 last_idx;
  logic                 step;
  logic                 do_arm;
  logic                 do_disarm;
  logic                 start_tick;
  logic                 push;
  logic                 push_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Elapsed count of the slot under scan, advanced and saturated.
  assign elap_cur = elap_r[idx_r];
  assign elap_inc = (elap_cur == '1) ? elap_cur : elap_cur + 1'b1;
  assign fire     = armed_r[idx_r] && (elap_inc > {1'b0, delay_r[idx_r]});
  assign last_idx = (32'(idx_r) == SLOTS - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && cmd_data.kind == CMD_TICK) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (step && last_idx) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!pend_v_r || out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    do_arm     = 1'b0;
    do_disarm  = 1'b0;
    start_tick = 1'b0;
    step       = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        cmd_pop    = cmd_valid;
        do_arm     = cmd_valid && cmd_data.kind == CMD_ARM;
        do_disarm  = cmd_valid && cmd_data.kind == CMD_DISARM;
        start_tick = cmd_valid && cmd_data.kind == CMD_TICK;
      end
      BK_SCAN: begin
        // Hold the scan when a second firing needs the output register and it is busy.
        step = !(fire && pend_v_r && !out_free);
        push = step && fire && pend_v_r;
      end
      BK_FLUSH: begin
        push      = pend_v_r && out_free;
        push_last = 1'b1;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      armed_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_tick) begin
        idx_r <= '0;
      end else if (step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (do_arm) begin
        armed_r[cmd_data.slot] <= 1'b1;
      end else if (do_disarm) begin
        armed_r[cmd_data.slot] <= 1'b0;
      end else if (step && fire) begin
        armed_r[idx_r] <= 1'b0;
      end
      if (step && fire) begin
        pend_v_r <= 1'b1;
      end else if (state_r == BK_FLUSH && push) begin
        pend_v_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_arm) begin
      chan_r[cmd_data.slot]  <= cmd_data.channel;
      act_r[cmd_data.slot]   <= cmd_data.action;
      delay_r[cmd_data.slot] <= cmd_data.delay;
      elap_r[cmd_data.slot]  <= '0;
    end else if (step && armed_r[idx_r]) begin
      elap_r[idx_r] <= elap_inc;
    end
    if (step && fire) begin
      pend_r <= {4'(idx_r), chan_r[idx_r], act_r[idx_r], 1'b0};
    end
    if (push) begin
      out_r <= {pend_r.fired_slot, pend_r.fired_channel, pend_r.fired_action, push_last};
    end
  end

endmodule
`default_nettype wire
